@@ hdl/mrse_pkg.sv @@
// Shared types, protocol constants and the CRC-16 byte step for the RTU slave engine.
// No dependencies; every other file imports this package.
package mrse_pkg;

  localparam int DEF_FRAME_BYTES = 64;
  localparam int DEF_REG_COUNT   = 16;
  localparam int DEF_COIL_COUNT  = 128;

  // Command codes on the input channel.
  localparam logic [2:0] CMD_RX      = 3'd0;
  localparam logic [2:0] CMD_TICK    = 3'd1;
  localparam logic [2:0] CMD_REG_WR  = 3'd2;
  localparam logic [2:0] CMD_COIL_WR = 3'd3;
  localparam logic [2:0] CMD_REG_RD  = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_STATION = 1'b0;
  localparam logic CFG_SILENCE = 1'b1;

  localparam logic [7:0] STATION_RESET = 8'd2;
  localparam logic [4:0] SILENCE_RESET = 5'd4;
  localparam logic [4:0] SILENCE_MAX   = 5'd31;

  // Function codes, exception flag and exception codes.
  localparam logic [7:0] FC_READ_COILS     = 8'h01;
  localparam logic [7:0] FC_READ_REGS      = 8'h03;
  localparam logic [7:0] FC_WRITE_REG      = 8'h06;
  localparam logic [7:0] EXC_FLAG          = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FUNC  = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'h02;
  localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'h03;
  localparam logic [7:0] BROADCAST_ADDR    = 8'h00;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] COIL_QTY_MAX = 16'd2000;

  localparam int MIN_FRAME_BYTES = 4;
  localparam int REQ_FRAME_BYTES = 8;
  localparam logic [7:0] HDR_BYTES = 8'd3;

  typedef struct packed {
    logic take;
    logic scan;
    logic serve;
    logic emit;
    logic gather;
  } ctl_t;

  typedef struct packed {
    logic out_free;
    logic frame_end;
    logic scan_done;
    logic frame_ok;
    logic need_gather;
    logic gather_done;
    logic emit_last;
  } stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

@@ hdl/mrse_ctrl.sv @@
// Sequencer for the RTU slave engine: input acceptance, frame scan, serve and reply walk.
// Depends on mrse_pkg for the command and status structs.
module mrse_ctrl import mrse_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CHECK, S_EMIT, S_GATHER} state_e;

  state_e state_q;

  always_comb begin
    in_stall_o   = !((state_q == S_IDLE) && stat_i.out_free);
    ctl_o.take   = in_valid_i && !in_stall_o;
    ctl_o.scan   = (state_q == S_SCAN);
    ctl_o.serve  = (state_q == S_CHECK);
    ctl_o.gather = (state_q == S_GATHER);
    ctl_o.emit   = (state_q == S_EMIT) && !stat_i.need_gather && stat_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (ctl_o.take && stat_i.frame_end) state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (stat_i.scan_done) state_q <= S_CHECK;
        end
        S_CHECK: begin
          state_q <= stat_i.frame_ok ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (stat_i.need_gather) state_q <= S_GATHER;
          else if (ctl_o.emit && stat_i.emit_last) state_q <= S_IDLE;
        end
        S_GATHER: begin
          if (stat_i.gather_done) state_q <= S_EMIT;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/mrse_dp.sv @@
// Datapath of the RTU slave engine: frame store, register and coil stores, CRC, reply bytes.
// Depends on mrse_pkg; driven by mrse_ctrl through ctl_t and reporting through stat_t.
module mrse_dp import mrse_pkg::*; #(
  parameter int FRAME_BYTES = DEF_FRAME_BYTES,
  parameter int REG_COUNT   = DEF_REG_COUNT,
  parameter int COIL_COUNT  = DEF_COIL_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  local_index_i,
  input  logic [15:0] local_value_i,
  input  logic [7:0]  station_i,
  input  logic [4:0]  silence_limit_i,
  input  logic        out_stall_i,
  input  ctl_t        ctl_i,
  output stat_t       stat_o,
  output logic        out_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic        is_read_reply_o,
  output logic [15:0] read_data_o
);

  localparam int CNT_W      = $clog2(FRAME_BYTES + 1);
  localparam int ADDR_W     = $clog2(FRAME_BYTES);
  localparam int RIDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int COIL_WORDS = (COIL_COUNT + 7) / 8;
  localparam int CW_W       = (COIL_WORDS > 1) ? $clog2(COIL_WORDS) : 1;

  typedef enum logic [1:0] {K_EXC, K_R03, K_W06, K_R01} kind_e;

  logic [7:0]  fmem [FRAME_BYTES];
  logic [15:0] regs_q [REG_COUNT];
  logic [7:0]  coil_q [COIL_WORDS];

  logic [CNT_W-1:0] count_q, len_q, raddr_q, ridx_q;
  logic             in_frame_q, rd_pend_q;
  logic [4:0]       sil_q, sil_next;
  logic [7:0]       rdata_q, rxlo_q, rxhi_q;
  logic [7:0]       hdr_q [6];
  logic [15:0]      crc_q, tcrc_q;
  kind_e            kind_q, kind_d;
  logic [7:0]       code_d, byte2_q, byte2_d, body_q, body_d, pos_q;
  logic             bcast_q, gathered_q;
  logic [7:0]       ci_q, acc_q;
  logic [8:0]       rem_q;
  logic [2:0]       bit_q;

  logic        take_rx, take_tick, finish, frame_ok;
  logic [7:0]  func;
  logic [15:0] start, qty;
  logic [16:0] span;
  logic [7:0]  off, reg_idx8, tx_d;
  logic [15:0] reg_word, local_rd;
  logic [9:0]  coil_bytes;
  logic        cbit;

  assign take_rx   = ctl_i.take && (cmd_i == CMD_RX);
  assign take_tick = ctl_i.take && (cmd_i == CMD_TICK);
  assign sil_next  = (sil_q == SILENCE_MAX) ? sil_q : sil_q + 5'd1;
  assign finish    = in_frame_q && (sil_next >= silence_limit_i);

  assign func  = hdr_q[1];
  assign start = {hdr_q[2], hdr_q[3]};
  assign qty   = {hdr_q[4], hdr_q[5]};
  assign span  = {1'b0, start} + {1'b0, qty};
  assign coil_bytes = ({1'b0, qty[8:0]} + 10'd7) >> 3;
  assign frame_ok = ((hdr_q[0] == BROADCAST_ADDR) || (hdr_q[0] == station_i))
                    && (crc_q == {rxhi_q, rxlo_q});

  // Request decode, evaluated while the scanned header is stable.
  always_comb begin
    kind_d = K_EXC;
    code_d = EXC_ILLEGAL_FUNC;
    if ((func != FC_READ_COILS) && (func != FC_READ_REGS) && (func != FC_WRITE_REG)) begin
      code_d = EXC_ILLEGAL_FUNC;
    end else if (len_q != CNT_W'(REQ_FRAME_BYTES)) begin
      code_d = EXC_ILLEGAL_VALUE;
    end else if (func == FC_READ_REGS) begin
      if (span > 17'(REG_COUNT)) code_d = EXC_ILLEGAL_ADDR;
      else kind_d = K_R03;
    end else if (func == FC_WRITE_REG) begin
      if (start >= 16'(REG_COUNT)) code_d = EXC_ILLEGAL_ADDR;
      else kind_d = K_W06;
    end else if ((qty == 16'd0) || (qty > COIL_QTY_MAX)) begin
      code_d = EXC_ILLEGAL_VALUE;
    end else if (span > 17'(COIL_COUNT)) begin
      code_d = EXC_ILLEGAL_ADDR;
    end else begin
      kind_d = K_R01;
    end
    case (kind_d)
      K_R03: begin
        body_d  = HDR_BYTES + {qty[6:0], 1'b0};
        byte2_d = {qty[6:0], 1'b0};
      end
      K_W06: begin
        body_d  = 8'd6;
        byte2_d = hdr_q[2];
      end
      K_R01: begin
        body_d  = HDR_BYTES + coil_bytes[7:0];
        byte2_d = coil_bytes[7:0];
      end
      default: begin
        body_d  = HDR_BYTES;
        byte2_d = code_d;
      end
    endcase
  end

  assign off      = pos_q - HDR_BYTES;
  assign reg_idx8 = start[7:0] + {1'b0, off[7:1]};
  assign reg_word = (reg_idx8 < 8'(REG_COUNT)) ? regs_q[RIDX_W'(reg_idx8)] : 16'd0;
  assign local_rd = (local_index_i < 8'(REG_COUNT)) ? regs_q[RIDX_W'(local_index_i)] : 16'd0;
  assign cbit     = coil_q[CW_W'(ci_q >> 3)][ci_q[2:0]];

  // Next reply byte: body bytes, then CRC low and high.
  always_comb begin
    if (pos_q < body_q) begin
      case (pos_q)
        8'd0: tx_d = hdr_q[0];
        8'd1: tx_d = (kind_q == K_EXC) ? (hdr_q[1] | EXC_FLAG) : hdr_q[1];
        8'd2: tx_d = byte2_q;
        default: begin
          case (kind_q)
            K_W06:   tx_d = hdr_q[pos_q[2:0]];
            K_R03:   tx_d = off[0] ? reg_word[7:0] : reg_word[15:8];
            K_R01:   tx_d = acc_q;
            default: tx_d = 8'h00;
          endcase
        end
      endcase
    end else if (pos_q == body_q) begin
      tx_d = tcrc_q[7:0];
    end else begin
      tx_d = tcrc_q[15:8];
    end
  end

  always_comb begin
    stat_o.out_free    = !out_valid_o || !out_stall_i;
    stat_o.frame_end   = (cmd_i == CMD_TICK) && finish
                         && (count_q >= CNT_W'(MIN_FRAME_BYTES));
    stat_o.scan_done   = ctl_i.scan && rd_pend_q && (ridx_q == len_q - CNT_W'(1));
    stat_o.frame_ok    = frame_ok;
    stat_o.need_gather = (kind_q == K_R01) && (pos_q >= HDR_BYTES) && (pos_q < body_q)
                         && !gathered_q;
    stat_o.gather_done = (bit_q == 3'd7);
    stat_o.emit_last   = (pos_q == body_q + 8'd1);
  end

  // Frame store with registered read port.
  always_ff @(posedge clk_i) begin
    if (take_rx && (count_q != CNT_W'(FRAME_BYTES))) begin
      fmem[count_q[ADDR_W-1:0]] <= data_byte_i;
    end
    rdata_q <= fmem[raddr_q[ADDR_W-1:0]];
  end

  // Header and received CRC capture during the scan.
  always_ff @(posedge clk_i) begin
    if (ctl_i.scan && rd_pend_q) begin
      for (int i = 0; i < 6; i++) begin
        if (ridx_q == CNT_W'(i)) hdr_q[i] <= rdata_q;
      end
      if (ridx_q == len_q - CNT_W'(2)) rxlo_q <= rdata_q;
      if (ridx_q == len_q - CNT_W'(1)) rxhi_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      len_q      <= '0;
      in_frame_q <= 1'b0;
      sil_q      <= '0;
      raddr_q    <= '0;
      ridx_q     <= '0;
      rd_pend_q  <= 1'b0;
      crc_q      <= CRC_INIT;
      tcrc_q     <= CRC_INIT;
      kind_q     <= K_EXC;
      byte2_q    <= '0;
      body_q     <= '0;
      pos_q      <= '0;
      bcast_q    <= 1'b0;
      gathered_q <= 1'b0;
      ci_q       <= '0;
      rem_q      <= '0;
      bit_q      <= '0;
      acc_q      <= '0;
      for (int i = 0; i < REG_COUNT; i++) regs_q[i] <= '0;
      for (int i = 0; i < COIL_WORDS; i++) coil_q[i] <= '0;
    end else begin
      if (take_rx) begin
        count_q    <= (count_q != CNT_W'(FRAME_BYTES)) ? count_q + CNT_W'(1) : '0;
        in_frame_q <= 1'b1;
        sil_q      <= '0;
      end
      if (take_tick && in_frame_q) begin
        if (finish) begin
          len_q      <= count_q;
          count_q    <= '0;
          in_frame_q <= 1'b0;
          sil_q      <= '0;
          raddr_q    <= '0;
          rd_pend_q  <= 1'b0;
          crc_q      <= CRC_INIT;
        end else begin
          sil_q <= sil_next;
        end
      end
      if (ctl_i.take && (cmd_i == CMD_REG_WR) && (local_index_i < 8'(REG_COUNT))) begin
        regs_q[RIDX_W'(local_index_i)] <= local_value_i;
      end
      if (ctl_i.take && (cmd_i == CMD_COIL_WR)
          && ({1'b0, local_index_i} < 9'(COIL_COUNT))) begin
        coil_q[CW_W'(local_index_i >> 3)][local_index_i[2:0]] <= (local_value_i != 16'd0);
      end

      if (ctl_i.scan) begin
        rd_pend_q <= (raddr_q < len_q);
        ridx_q    <= raddr_q;
        if (raddr_q < len_q) raddr_q <= raddr_q + CNT_W'(1);
        if (rd_pend_q && (ridx_q < len_q - CNT_W'(2))) crc_q <= crc_byte(crc_q, rdata_q);
      end

      if (ctl_i.serve) begin
        kind_q     <= kind_d;
        byte2_q    <= byte2_d;
        body_q     <= body_d;
        pos_q      <= '0;
        tcrc_q     <= CRC_INIT;
        bcast_q    <= (hdr_q[0] == BROADCAST_ADDR);
        gathered_q <= 1'b0;
        ci_q       <= start[7:0];
        rem_q      <= qty[8:0];
        bit_q      <= '0;
        acc_q      <= '0;
        if (frame_ok && (kind_d == K_W06)) regs_q[RIDX_W'(start)] <= qty;
      end

      if (ctl_i.gather) begin
        if (rem_q != 9'd0) begin
          acc_q[bit_q] <= cbit;
          ci_q         <= ci_q + 8'd1;
          rem_q        <= rem_q - 9'd1;
        end
        bit_q <= bit_q + 3'd1;
        if (bit_q == 3'd7) gathered_q <= 1'b1;
      end

      if (ctl_i.emit) begin
        if (pos_q < body_q) tcrc_q <= crc_byte(tcrc_q, tx_d);
        pos_q      <= pos_q + 8'd1;
        gathered_q <= 1'b0;
        acc_q      <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (ctl_i.take && (cmd_i == CMD_REG_RD)) begin
      out_valid_o <= 1'b1;
    end else if (ctl_i.emit) begin
      out_valid_o <= !bcast_q;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take && (cmd_i == CMD_REG_RD)) begin
      tx_byte_o       <= 8'h00;
      tx_last_o       <= 1'b0;
      is_read_reply_o <= 1'b1;
      read_data_o     <= local_rd;
    end else if (ctl_i.emit) begin
      tx_byte_o       <= tx_d;
      tx_last_o       <= stat_o.emit_last;
      is_read_reply_o <= 1'b0;
      read_data_o     <= 16'h0000;
    end
  end

endmodule

@@ hdl/modbus_rtu_slave_engine_core.sv @@
// A local register read shows its transaction on the output in the cycle after acceptance.
// A frame end scans the stored frame, decodes the request and then sends one reply byte
// per cycle while the output is not stalled, each read-coils data byte first being gathered
// bit by bit; no new input transaction is taken during that walk.
// Reset is asynchronous, active low; it clears counters, registers and coils; the frame store holds no reset.
module modbus_rtu_slave_engine_core import mrse_pkg::*; #(
  parameter int FRAME_BYTES = DEF_FRAME_BYTES,
  parameter int REG_COUNT   = DEF_REG_COUNT,
  parameter int COIL_COUNT  = DEF_COIL_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  local_index_i,
  input  logic [15:0] local_value_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic        is_read_reply_o,
  output logic [15:0] read_data_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  ctl_t       ctl;
  stat_t      stat;
  logic [7:0] station_q;
  logic [4:0] silence_q;

  // Always ready; the user must write config only while the engine is idle; the block does not check it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= STATION_RESET;
      silence_q <= SILENCE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_STATION: station_q <= cfg_data_i;
        CFG_SILENCE: silence_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // The controller decides when a transaction is taken and walks the frame and reply.
  mrse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  // The datapath holds all stores, the CRC units and the output register.
  mrse_dp #(
    .FRAME_BYTES (FRAME_BYTES),
    .REG_COUNT   (REG_COUNT),
    .COIL_COUNT  (COIL_COUNT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd_i),
    .data_byte_i     (data_byte_i),
    .local_index_i   (local_index_i),
    .local_value_i   (local_value_i),
    .station_i       (station_q),
    .silence_limit_i (silence_q),
    .out_stall_i     (out_stall_i),
    .ctl_i           (ctl),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .tx_byte_o       (tx_byte_o),
    .tx_last_o       (tx_last_o),
    .is_read_reply_o (is_read_reply_o),
    .read_data_o     (read_data_o)
  );

endmodule

@@ tb/sv/modbus_rtu_slave_engine_core_tb.sv @@
// Testbench for the RTU slave engine core: frames, ticks and local access.
// A scoreboard class predicts the reply bytes and checks them in order.
// Depends on mrse_pkg and modbus_rtu_slave_engine_core.
`timescale 1ns / 100ps

module modbus_rtu_slave_engine_core_tb;
  import mrse_pkg::*;

  localparam int FRAME_BYTES = DEF_FRAME_BYTES;
  localparam int REG_COUNT   = DEF_REG_COUNT;
  localparam int COIL_COUNT  = DEF_COIL_COUNT;
  localparam int CYCLE_LIMIT = 2000000;

  // One output transaction of the block.
  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        is_read_reply;
    logic [15:0] read_data;
  } reply_t;

  // The scoreboard holds its own copy of the engine state and a queue of replies
  // that are still owed by the block.
  class modbus_scoreboard;
    logic [7:0]  frame_mem [FRAME_BYTES];
    int unsigned frame_len;
    bit          receiving;
    int unsigned quiet_ticks;
    logic [15:0] regs [REG_COUNT];
    bit          coils [COIL_COUNT];
    logic [7:0]  station;
    logic [4:0]  silence_lim;
    reply_t      pending_replies [$];
    int          errors;

    function new();
      frame_len = 0;
      receiving = 0;
      quiet_ticks = 0;
      errors = 0;
      station = STATION_RESET;
      silence_lim = SILENCE_RESET;
      foreach (regs[i]) regs[i] = '0;
      foreach (coils[i]) coils[i] = 0;
      foreach (frame_mem[i]) frame_mem[i] = '0;
    endfunction

    static function logic [15:0] crc_of(logic [7:0] buf_b [$]);
      logic [15:0] c;
      c = 16'hFFFF;
      foreach (buf_b[i]) begin
        c ^= {8'h00, buf_b[i]};
        for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
    endfunction

    function void push_tx(logic [7:0] bytes [$]);
      logic [15:0] c;
      reply_t r;
      c = crc_of(bytes);
      bytes.push_back(c[7:0]);
      bytes.push_back(c[15:8]);
      foreach (bytes[k]) begin
        r = '0;
        r.tx_byte = bytes[k];
        r.tx_last = (k == bytes.size() - 1);
        pending_replies.push_back(r);
      end
    endfunction

    // Decodes a complete request and returns the reply body (without CRC).
    function void serve_request(int unsigned len, output logic [7:0] body [$]);
      logic [7:0] a, f, acc;
      int unsigned start, qty;
      a = frame_mem[0];
      f = frame_mem[1];
      body = {};
      if (f != FC_READ_COILS && f != FC_READ_REGS && f != FC_WRITE_REG) begin
        body = {a, f | EXC_FLAG, EXC_ILLEGAL_FUNC};
        return;
      end
      if (len != REQ_FRAME_BYTES) begin
        body = {a, f | EXC_FLAG, EXC_ILLEGAL_VALUE};
        return;
      end
      start = {frame_mem[2], frame_mem[3]};
      qty = {frame_mem[4], frame_mem[5]};
      if (f == FC_READ_REGS) begin
        if (start + qty > REG_COUNT) begin
          body = {a, f | EXC_FLAG, EXC_ILLEGAL_ADDR};
          return;
        end
        body = {a, FC_READ_REGS, 8'(qty * 2)};
        for (int i = 0; i < qty; i++) begin
          body.push_back(regs[start + i][15:8]);
          body.push_back(regs[start + i][7:0]);
        end
      end else if (f == FC_WRITE_REG) begin
        if (start >= REG_COUNT) begin
          body = {a, f | EXC_FLAG, EXC_ILLEGAL_ADDR};
          return;
        end
        regs[start] = 16'(qty);
        for (int i = 0; i < 6; i++) body.push_back(frame_mem[i]);
      end else begin
        if (qty < 1 || qty > 2000) begin
          body = {a, f | EXC_FLAG, EXC_ILLEGAL_VALUE};
          return;
        end
        if (start + qty > COIL_COUNT) begin
          body = {a, f | EXC_FLAG, EXC_ILLEGAL_ADDR};
          return;
        end
        body = {a, FC_READ_COILS, 8'((qty + 7) / 8)};
        acc = '0;
        for (int i = 0; i < qty; i++) begin
          if (coils[start + i]) acc[i % 8] = 1'b1;
          if (i % 8 == 7 || i == qty - 1) begin
            body.push_back(acc);
            acc = '0;
          end
        end
      end
    endfunction

    function void close_frame();
      int unsigned len;
      logic [7:0] head [$];
      logic [7:0] body [$];
      logic [15:0] rx_crc;
      len = frame_len;
      receiving = 0;
      frame_len = 0;
      quiet_ticks = 0;
      if (len < MIN_FRAME_BYTES || len > FRAME_BYTES) return;
      if (frame_mem[0] != BROADCAST_ADDR && frame_mem[0] != station) return;
      for (int i = 0; i < len - 2; i++) head.push_back(frame_mem[i]);
      rx_crc = {frame_mem[len - 1], frame_mem[len - 2]};
      if (rx_crc != crc_of(head)) return;
      serve_request(len, body);
      // Broadcasts act on the state but are never answered.
      if (frame_mem[0] != BROADCAST_ADDR) push_tx(body);
    endfunction

    function void note_input(logic [2:0] cmd, logic [7:0] data, logic [7:0] idx,
                             logic [15:0] val);
      reply_t r;
      case (cmd)
        CMD_RX: begin
          if (frame_len < FRAME_BYTES) begin
            frame_mem[frame_len] = data;
            frame_len++;
          end else begin
            frame_len = 0;
          end
          receiving = 1;
          quiet_ticks = 0;
        end
        CMD_TICK: begin
          if (receiving) begin
            if (quiet_ticks < 31) quiet_ticks++;
            if (quiet_ticks >= silence_lim) close_frame();
          end
        end
        CMD_REG_WR: if (idx < REG_COUNT) regs[idx] = val;
        CMD_COIL_WR: if (idx < COIL_COUNT) coils[idx] = (val != 0);
        CMD_REG_RD: begin
          r = '0;
          r.is_read_reply = 1'b1;
          r.read_data = (idx < REG_COUNT) ? regs[idx] : 16'h0000;
          pending_replies.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_reply(reply_t got);
      reply_t exp_r;
      if (pending_replies.size() == 0) begin
        $error("unexpected output transaction tx_byte=%h", got.tx_byte);
        errors++;
        return;
      end
      exp_r = pending_replies.pop_front();
      if (got.tx_byte !== exp_r.tx_byte) begin
        $error("tx_byte expected %h actual %h", exp_r.tx_byte, got.tx_byte);
        errors++;
      end
      if (got.tx_last !== exp_r.tx_last) begin
        $error("tx_last expected %b actual %b", exp_r.tx_last, got.tx_last);
        errors++;
      end
      if (got.is_read_reply !== exp_r.is_read_reply) begin
        $error("is_read_reply expected %b actual %b", exp_r.is_read_reply, got.is_read_reply);
        errors++;
      end
      if (got.read_data !== exp_r.read_data) begin
        $error("read_data expected %h actual %h", exp_r.read_data, got.read_data);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic [7:0]  local_index_i = '0;
  logic [15:0] local_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  tx_byte_o;
  logic        tx_last_o;
  logic        is_read_reply_o;
  logic [15:0] read_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [7:0]  cfg_data_i = '0;

  modbus_scoreboard sb = new();
  int          cycle_count = 0;
  // Set to ask the receiver for a long hold-off; cleared once the hold-off starts.
  bit          hold_request = 0;
  int          item_count = 0;

  always #4 clk_i = ~clk_i;

  modbus_rtu_slave_engine_core DUT (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .cmd_i, .data_byte_i, .local_index_i, .local_value_i,
    .out_valid_o, .out_stall_i, .tx_byte_o, .tx_last_o, .is_read_reply_o, .read_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Both handshakes are sampled at the rising edge, before the new drive values
  // (nonblocking) take effect, so the sampled values are the ones seen by the block.
  always @(posedge clk_i) begin
    reply_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{tx_byte_o, tx_last_o, is_read_reply_o, read_data_o};
      sb.check_reply(got);
    end
  end

  // Receiver stall pattern: phases of no stalling, random stalling and heavy
  // stalling, plus a long hold-off when the stimulus asks for it.
  always @(posedge clk_i) begin
    int mode_left;
    int mode;
    int hold_left;
    if (hold_request && hold_left == 0) begin
      hold_left = 400;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sender burst state: an item is offered right away within a burst; between
  // bursts a random gap of idle cycles is inserted.
  int burst_left = 0;

  // Offers one item and waits for its transaction; the scoreboard notes it on
  // acceptance. Valid stays high into the next item of a burst and is dropped
  // before a gap or whenever the sender pauses.
  task automatic send_item(logic [2:0] cmd, logic [7:0] data, logic [7:0] idx,
                           logic [15:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    data_byte_i <= data;
    local_index_i <= idx;
    local_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(cmd, data, idx, val);
    item_count++;
  endtask

  task automatic send_frame(logic [7:0] bytes [$]);
    foreach (bytes[i]) send_item(CMD_RX, bytes[i], 8'($urandom), 16'($urandom));
  endtask

  // Builds a frame with a correct CRC appended.
  function automatic void seal_frame(ref logic [7:0] bytes [$]);
    logic [15:0] c;
    c = modbus_scoreboard::crc_of(bytes);
    bytes.push_back(c[7:0]);
    bytes.push_back(c[15:8]);
  endfunction

  // Ends the current frame with enough ticks for the current silence limit.
  task automatic end_frame();
    repeat (int'(sb.silence_lim) + 1) send_item(CMD_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    // A frame that produces no reply can still be scanned: allow the full scan.
    repeat (FRAME_BYTES + 20) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_STATION) sb.station = value;
    else sb.silence_lim = value[4:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random request: mostly well formed to this station, some broadcasts,
  // foreign addresses, odd lengths and broken CRCs.
  task automatic random_request();
    logic [7:0] fr [$];
    logic [7:0] fc;
    logic [15:0] start, qty;
    int kind;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 5))
      0, 1: fc = FC_READ_REGS;
      2: fc = FC_WRITE_REG;
      3, 4: fc = FC_READ_COILS;
      default: fc = 8'($urandom);
    endcase
    if (fc == FC_READ_COILS) begin
      start = 16'($urandom_range(0, COIL_COUNT + 2));
      qty = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    end else begin
      start = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, REG_COUNT));
      qty = (fc == FC_WRITE_REG) ? 16'($urandom) : 16'($urandom_range(0, 8));
    end
    fr = {(kind < 80) ? sb.station : ((kind < 90) ? BROADCAST_ADDR : 8'($urandom)), fc,
          start[15:8], start[7:0], qty[15:8], qty[7:0]};
    if (kind >= 94) repeat ($urandom_range(1, 3)) fr.push_back(8'($urandom));
    if (kind >= 97) fr = fr[0:$urandom_range(0, 3)];
    seal_frame(fr);
    if ($urandom_range(0, 15) == 0) fr[$] ^= 8'(1 << $urandom_range(0, 7));
    send_frame(fr);
    end_frame();
  endtask

  task automatic random_local();
    logic [2:0] cmd;
    cmd = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(2, 4));
    send_item(cmd, 8'($urandom), ($urandom_range(0, 3) == 0) ? 8'($urandom) :
              8'($urandom_range(0, REG_COUNT - 1)), 16'($urandom));
  endtask

  initial begin
    logic [7:0] fr [$];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: register and coil extremes, each function code, exceptions,
    // broadcast and a tick while idle.
    send_item(CMD_TICK, 8'h00, 8'h00, 16'h0000);
    send_item(CMD_REG_WR, 8'hFF, 8'h00, 16'hFFFF);
    send_item(CMD_REG_WR, 8'h00, 8'(REG_COUNT - 1), 16'h8001);
    send_item(CMD_REG_WR, 8'h00, 8'hFF, 16'h1234);
    send_item(CMD_COIL_WR, 8'h00, 8'h00, 16'h0001);
    send_item(CMD_COIL_WR, 8'h00, 8'(COIL_COUNT - 1), 16'hFFFF);
    send_item(CMD_COIL_WR, 8'h00, 8'hFF, 16'h0001);
    send_item(CMD_REG_RD, 8'h00, 8'h00, 16'h0000);
    send_item(CMD_REG_RD, 8'h00, 8'hFF, 16'h0000);
    send_item(3'd7, 8'hFF, 8'hFF, 16'hFFFF);
    fr = {STATION_RESET, FC_READ_REGS, 8'h00, 8'h00, 8'h00, 8'(REG_COUNT)};
    seal_frame(fr); send_frame(fr); end_frame();
    fr = {STATION_RESET, FC_READ_COILS, 8'h00, 8'h00, 8'h00, 8'(COIL_COUNT)};
    seal_frame(fr); send_frame(fr); end_frame();
    fr = {STATION_RESET, FC_WRITE_REG, 8'h00, 8'h05, 8'hAB, 8'hCD};
    seal_frame(fr); send_frame(fr); end_frame();
    fr = {BROADCAST_ADDR, FC_WRITE_REG, 8'h00, 8'h06, 8'h55, 8'hAA};
    seal_frame(fr); send_frame(fr); end_frame();
    fr = {STATION_RESET, 8'h07, 8'h00};
    seal_frame(fr); send_frame(fr); end_frame();
    fr = {STATION_RESET, FC_READ_REGS, 8'h00, 8'h10, 8'h00, 8'h00};
    seal_frame(fr); send_frame(fr); end_frame();
    fr = {STATION_RESET, FC_READ_COILS, 8'h00, 8'h00, 8'h07, 8'hD1};
    seal_frame(fr); send_frame(fr); end_frame();
    send_item(CMD_REG_RD, 8'h00, 8'h06, 16'h0000);
    wait_drained();

    // Store full: 65 bytes restart the count, then the request that follows is
    // stored from the start and served.
    fr = {};
    for (int i = 0; i <= FRAME_BYTES; i++) fr.push_back(8'($urandom));
    send_frame(fr);
    fr = {STATION_RESET, FC_READ_REGS, 8'h00, 8'h00, 8'h00, 8'h02};
    seal_frame(fr); send_frame(fr); end_frame();

    // Long receiver hold-off with the sender still offering reads.
    hold_request = 1;
    repeat (20) send_item(CMD_REG_RD, 8'h00, 8'($urandom_range(0, 15)), 16'h0000);
    wait_drained();

    // Random phases across several configurations, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_cfg(CFG_STATION, 8'hFF); write_cfg(CFG_SILENCE, 5'd20); end
        1: begin write_cfg(CFG_STATION, 8'h00); write_cfg(CFG_SILENCE, 5'd4); end
        2: begin write_cfg(CFG_STATION, 8'h01); write_cfg(CFG_SILENCE, 5'd0); end
        3: begin write_cfg(CFG_STATION, 8'($urandom)); write_cfg(CFG_SILENCE, 5'd31); end
        4: begin write_cfg(CFG_STATION, 8'($urandom_range(1, 254))); write_cfg(CFG_SILENCE, 5'd1); end
        default: begin write_cfg(CFG_STATION, 8'h2A); write_cfg(CFG_SILENCE, 5'($urandom_range(4, 20))); end
      endcase
      for (int k = 0; k < 3; k++) begin
        if ($urandom_range(0, 2) == 0) random_local();
        else random_request();
        // Noise ticks between frames.
        if ($urandom_range(0, 4) == 0)
          send_item(CMD_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
      end
      wait_drained();
    end

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.pending_replies.size() != 0)
        $error("%0d expected output transactions never arrived", sb.pending_replies.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ modbus_rtu_slave_engine_core.f @@
hdl/mrse_pkg.sv
hdl/mrse_ctrl.sv
hdl/mrse_dp.sv
hdl/modbus_rtu_slave_engine_core.sv
tb/sv/modbus_rtu_slave_engine_core_tb.sv
